/* design/gscp_pkg.sv */
// Package for the grid snap and collinear prune unit: widths, register codes,
// shared types and the per-axis rounding and saturation function.
// No dependencies.
`default_nettype none

package gscp_pkg;

	// Coordinate and arithmetic widths
	localparam int COORD_BITS = 40;
	localparam int STEP_W     = 32;
	localparam int MAG_W      = COORD_BITS + 1;
	localparam int IDX_W      = COORD_BITS + 3;
	localparam int DIR_W      = IDX_W + 1;
	localparam int PROD_W     = 2 * DIR_W;
	localparam int SUM_W      = ((IDX_W > STEP_W + 1) ? IDX_W : STEP_W + 1) + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = (COORD_BITS > STEP_W) ? COORD_BITS : STEP_W;
	localparam int DIV_CNT_W  = $clog2(MAG_W);
	localparam int MUL_CNT_W  = $clog2(DIR_W);
	localparam int KEPT_MIN   = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_X   = 3'd0,
		REG_STEP_Y   = 3'd1,
		REG_OFFSET_X = 3'd2,
		REG_OFFSET_Y = 3'd3,
		REG_PRUNE    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [STEP_W-1:0]            step_x;
		logic [STEP_W-1:0]            step_y;
		logic signed [COORD_BITS-1:0] off_x;
		logic signed [COORD_BITS-1:0] off_y;
		logic                         prune;
	} cfg_t;

	// One snapped vertex passed from the front end to the back end
	typedef struct packed {
		logic signed [IDX_W-1:0]      idx_x;
		logic signed [IDX_W-1:0]      idx_y;
		logic signed [COORD_BITS-1:0] snap_x;
		logic signed [COORD_BITS-1:0] snap_y;
		logic                         path_end;
	} snap_item_t;

	typedef struct packed {
		logic signed [IDX_W-1:0]      idx;
		logic signed [COORD_BITS-1:0] snapped;
	} axis_snap_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_DIV,
		FS_DONE
	} front_state_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_EVAL,
		BS_MUL,
		BS_COMMIT,
		BS_FLUSH
	} back_state_t;

	// Rounds the quotient half away from zero and forms the snapped coordinate.
	function automatic axis_snap_t snap_finish(
		input logic signed [COORD_BITS-1:0] c,
		input logic                         neg,
		input logic [MAG_W-1:0]             q,
		input logic [STEP_W-1:0]            r,
		input logic [STEP_W-1:0]            s
	);
		logic                     up;
		logic                     sub;
		logic [MAG_W:0]           qi;
		logic signed [IDX_W-1:0]  qs;
		logic [STEP_W-1:0]        sr;
		logic signed [SUM_W-1:0]  ce;
		logic signed [SUM_W-1:0]  adj;
		logic signed [SUM_W-1:0]  res;
		logic signed [SUM_W-1:0]  hi;
		logic signed [SUM_W-1:0]  lo;
		axis_snap_t               o;
		up  = ({r, 1'b0} >= {1'b0, s});
		qi  = {1'b0, q} + {{MAG_W{1'b0}}, up};
		qs  = $signed({1'b0, qi});
		o.idx = neg ? -qs : qs;
		sr  = s - r;
		ce  = SUM_W'(c);
		adj = up ? $signed({{(SUM_W-STEP_W){1'b0}}, sr})
		         : $signed({{(SUM_W-STEP_W){1'b0}}, r});
		sub = up ? neg : !neg;
		res = sub ? ce - adj : ce + adj;
		hi  = $signed({{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
		lo  = -hi - SUM_W'(1);
		if (COORD_BITS >= 64) begin
			o.snapped = res[COORD_BITS-1:0];
		end else if (res > hi) begin
			o.snapped = hi[COORD_BITS-1:0];
		end else if (res < lo) begin
			o.snapped = lo[COORD_BITS-1:0];
		end else begin
			o.snapped = res[COORD_BITS-1:0];
		end
		return o;
	endfunction

endpackage

`default_nettype wire

/* design/gscp_if.sv */
// Channel interfaces of the grid snap and collinear prune unit: vertex input,
// snapped vertex output and configuration write. Depends on gscp_pkg.
`default_nettype none

interface gscp_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [gscp_pkg::COORD_BITS-1:0] point_x;
	logic signed [gscp_pkg::COORD_BITS-1:0] point_y;
	logic                                  path_end;
	modport source(output valid, point_x, point_y, path_end, input ready);
	modport sink(input valid, point_x, point_y, path_end, output ready);
endinterface

interface gscp_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [gscp_pkg::COORD_BITS-1:0] snapped_x;
	logic signed [gscp_pkg::COORD_BITS-1:0] snapped_y;
	logic                                  last_of_path;
	logic                                  too_few_points;
	modport source(output valid, snapped_x, snapped_y, last_of_path, too_few_points,
		input ready);
	modport sink(input valid, snapped_x, snapped_y, last_of_path, too_few_points,
		output ready);
endinterface

interface gscp_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [gscp_pkg::CFG_IDX_W-1:0]       index;
	logic [gscp_pkg::CFG_DATA_W-1:0]      data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/grid_snap_collinear_prune_unit.sv */
// A vertex passes from acceptance through 41 division steps to the queue, then
// through the back end states to the output register (with a flush state for
// the last_of_path request), plus the serial cross product where needed.
// The bit-serial grid divider takes a new vertex only after the last one has
// gone to the queue; a vertex needing the collinear test also holds the back end.
// Reset clears all control and path state and loads the configuration reset
// values at once; there is no clearing pass.
`default_nettype none

module grid_snap_collinear_prune_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	gscp_in_if.sink     in_ch,
	gscp_out_if.source  out_ch,
	gscp_cfg_if.sink    cfg
);

	gscp_pkg::cfg_t       cfg_q;
	gscp_pkg::snap_item_t push_item, pop_item;
	logic push, pop, q_full, q_not_empty;

	// Configuration registers; writes to unused indexes are ignored
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_x <= gscp_pkg::STEP_W'(1);
			cfg_q.step_y <= gscp_pkg::STEP_W'(1);
			cfg_q.off_x  <= '0;
			cfg_q.off_y  <= '0;
			cfg_q.prune  <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				gscp_pkg::REG_STEP_X:   cfg_q.step_x <= cfg.data[gscp_pkg::STEP_W-1:0];
				gscp_pkg::REG_STEP_Y:   cfg_q.step_y <= cfg.data[gscp_pkg::STEP_W-1:0];
				gscp_pkg::REG_OFFSET_X: cfg_q.off_x  <= cfg.data[gscp_pkg::COORD_BITS-1:0];
				gscp_pkg::REG_OFFSET_Y: cfg_q.off_y  <= cfg.data[gscp_pkg::COORD_BITS-1:0];
				gscp_pkg::REG_PRUNE:    cfg_q.prune  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	gscp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	gscp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (q_not_empty)
	);

	gscp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_item      (pop_item),
		.pop         (pop),
		.out_ch      (out_ch)
	);

endmodule

`default_nettype wire

/* design/gscp_front.sv */
// Front end: accepts a vertex, divides both offset coordinates by the grid
// steps bit by bit and rounds them. Depends on gscp_pkg and gscp_if.
`default_nettype none

module gscp_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	gscp_in_if.sink                   in_ch,
	input  wire gscp_pkg::cfg_t       cfg,
	input  wire logic                 q_full,
	output logic                      push,
	output gscp_pkg::snap_item_t      push_item
);

	gscp_pkg::front_state_t state_q, state_nxt;
	logic [gscp_pkg::DIV_CNT_W-1:0] cnt_q;

	// Per-axis lanes: 0 is x, 1 is y
	logic signed [gscp_pkg::COORD_BITS-1:0] coord_q [2];
	logic                                   neg_q   [2];
	logic [gscp_pkg::MAG_W-1:0]             mag_q   [2];
	logic [gscp_pkg::STEP_W:0]              rem_q   [2];
	logic [gscp_pkg::STEP_W-1:0]            step_q  [2];
	logic                                   end_q;

	logic accept;
	logic div_last;
	logic signed [gscp_pkg::COORD_BITS-1:0] in_c   [2];
	logic signed [gscp_pkg::COORD_BITS-1:0] in_off [2];
	logic [gscp_pkg::STEP_W-1:0]            in_step[2];
	logic signed [gscp_pkg::MAG_W-1:0]      diff   [2];
	logic [gscp_pkg::STEP_W:0]              sh     [2];
	logic                                   ge     [2];
	gscp_pkg::axis_snap_t                   fin    [2];

	// Outputs of the sequencer
	always_comb begin
		in_ch.ready = (state_q == gscp_pkg::FS_IDLE);
		accept      = in_ch.valid && in_ch.ready;
		div_last    = (cnt_q == gscp_pkg::DIV_CNT_W'(gscp_pkg::MAG_W - 1));
		push        = (state_q == gscp_pkg::FS_DONE) && !q_full;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gscp_pkg::FS_IDLE: if (accept)   state_nxt = gscp_pkg::FS_DIV;
			gscp_pkg::FS_DIV:  if (div_last) state_nxt = gscp_pkg::FS_DONE;
			gscp_pkg::FS_DONE: if (!q_full)  state_nxt = gscp_pkg::FS_IDLE;
			default:                         state_nxt = gscp_pkg::FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gscp_pkg::FS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == gscp_pkg::FS_DIV) begin
				cnt_q <= cnt_q + gscp_pkg::DIV_CNT_W'(1);
			end
		end
	end

	// Offset subtraction and one restoring division step per lane
	always_comb begin
		in_c[0]    = in_ch.point_x;
		in_c[1]    = in_ch.point_y;
		in_off[0]  = cfg.off_x;
		in_off[1]  = cfg.off_y;
		in_step[0] = (cfg.step_x == '0) ? gscp_pkg::STEP_W'(1) : cfg.step_x;
		in_step[1] = (cfg.step_y == '0) ? gscp_pkg::STEP_W'(1) : cfg.step_y;
		for (int i = 0; i < 2; i++) begin
			diff[i] = {in_c[i][gscp_pkg::COORD_BITS-1], in_c[i]}
				- {in_off[i][gscp_pkg::COORD_BITS-1], in_off[i]};
			sh[i]   = {rem_q[i][gscp_pkg::STEP_W-1:0], mag_q[i][gscp_pkg::MAG_W-1]};
			ge[i]   = (sh[i] >= {1'b0, step_q[i]});
			fin[i]  = gscp_pkg::snap_finish(coord_q[i], neg_q[i], mag_q[i],
				rem_q[i][gscp_pkg::STEP_W-1:0], step_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			if (accept) begin
				coord_q[i] <= in_c[i];
				step_q[i]  <= in_step[i];
				neg_q[i]   <= diff[i][gscp_pkg::MAG_W-1];
				mag_q[i]   <= diff[i][gscp_pkg::MAG_W-1] ? gscp_pkg::MAG_W'(-diff[i])
				                                        : gscp_pkg::MAG_W'(diff[i]);
				rem_q[i]   <= '0;
			end else if (state_q == gscp_pkg::FS_DIV) begin
				rem_q[i] <= ge[i] ? sh[i] - {1'b0, step_q[i]} : sh[i];
				mag_q[i] <= {mag_q[i][gscp_pkg::MAG_W-2:0], ge[i]};
			end
		end
		if (accept) begin
			end_q <= in_ch.path_end;
		end
	end

	// Snapped vertex toward the queue
	always_comb begin
		push_item.idx_x    = fin[0].idx;
		push_item.idx_y    = fin[1].idx;
		push_item.snap_x   = fin[0].snapped;
		push_item.snap_y   = fin[1].snapped;
		push_item.path_end = end_q;
	end

endmodule

`default_nettype wire

/* design/gscp_queue.sv */
// Two-entry queue of snapped vertices between the front and back ends.
// Depends on gscp_pkg.
`default_nettype none

module gscp_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire gscp_pkg::snap_item_t push_item,
	output logic                      full,
	input  wire logic                 pop,
	output gscp_pkg::snap_item_t      pop_item,
	output logic                      not_empty
);

	gscp_pkg::snap_item_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// Occupancy flags
	always_comb begin
		full      = (count_q == 2'd2);
		not_empty = (count_q != 2'd0);
		pop_item  = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

/* design/gscp_back.sv */
// Back end: drops repeated grid points, merges collinear runs with a
// bit-serial cross product, holds the newest vertex and drives the output
// register. Depends on gscp_pkg and gscp_if.
`default_nettype none

module gscp_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gscp_pkg::cfg_t       cfg,
	input  wire logic                 q_not_empty,
	input  wire gscp_pkg::snap_item_t q_item,
	output logic                      pop,
	gscp_out_if.source                out_ch
);

	gscp_pkg::back_state_t state_q, state_nxt;

	// Path state
	logic signed [gscp_pkg::IDX_W-1:0]      last_x_q, last_y_q;
	logic signed [gscp_pkg::DIR_W-1:0]      base_x_q, base_y_q;
	logic signed [gscp_pkg::COORD_BITS-1:0] held_x_q, held_y_q;
	logic                                   have_first_q;
	logic                                   no_base_q;
	logic [1:0]                             kept_q;

	// Current vertex and its decision
	gscp_pkg::snap_item_t                   cur_q;
	logic signed [gscp_pkg::DIR_W-1:0]      dx_q, dy_q;
	logic                                   keep_q, replace_q;

	// Cross product datapath
	logic signed [gscp_pkg::PROD_W-1:0]     acc_q, ma_q, mb_q;
	logic [gscp_pkg::DIR_W-1:0]             rx_q, ry_q;
	logic [gscp_pkg::MUL_CNT_W-1:0]         mcnt_q;

	// Output register
	logic                                   out_valid_q;
	logic signed [gscp_pkg::COORD_BITS-1:0] out_x_q, out_y_q;
	logic                                   out_last_q, out_few_q;

	logic out_free, zero_delta, need_mul, mul_last, emit_held;
	logic commit_fire, flush_fire, eval_commit;
	logic signed [gscp_pkg::PROD_W-1:0] term, acc_nxt;

	// Serial multiply step: base_x * dy - base_y * dx
	always_comb begin
		term    = (ry_q[0] ? ma_q : '0) - (rx_q[0] ? mb_q : '0);
		mul_last = (mcnt_q == gscp_pkg::MUL_CNT_W'(gscp_pkg::DIR_W - 1));
		acc_nxt = mul_last ? acc_q - term : acc_q + term;
	end

	// Sequencer outputs
	always_comb begin
		out_free    = !out_valid_q || out_ch.ready;
		zero_delta  = (dx_q == '0) && (dy_q == '0);
		need_mul    = have_first_q && !zero_delta && cfg.prune && !no_base_q;
		eval_commit = (state_q == gscp_pkg::BS_EVAL) && !need_mul;
		pop         = (state_q == gscp_pkg::BS_IDLE) && q_not_empty;
		emit_held   = keep_q && !replace_q && have_first_q;
		commit_fire = (state_q == gscp_pkg::BS_COMMIT) && (!emit_held || out_free);
		flush_fire  = (state_q == gscp_pkg::BS_FLUSH) && out_free;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gscp_pkg::BS_IDLE: if (pop) state_nxt = gscp_pkg::BS_EVAL;
			gscp_pkg::BS_EVAL: begin
				state_nxt = need_mul ? gscp_pkg::BS_MUL : gscp_pkg::BS_COMMIT;
			end
			gscp_pkg::BS_MUL: if (mul_last) state_nxt = gscp_pkg::BS_COMMIT;
			gscp_pkg::BS_COMMIT: begin
				if (commit_fire) begin
					state_nxt = cur_q.path_end ? gscp_pkg::BS_FLUSH : gscp_pkg::BS_IDLE;
				end
			end
			gscp_pkg::BS_FLUSH: if (flush_fire) state_nxt = gscp_pkg::BS_IDLE;
			default: state_nxt = gscp_pkg::BS_IDLE;
		endcase
	end

	// Control and path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gscp_pkg::BS_IDLE;
			have_first_q <= 1'b0;
			no_base_q    <= 1'b1;
			kept_q       <= 2'd0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			base_x_q     <= '0;
			base_y_q     <= '0;
			held_x_q     <= '0;
			held_y_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (commit_fire && keep_q) begin
				last_x_q <= cur_q.idx_x;
				last_y_q <= cur_q.idx_y;
				held_x_q <= cur_q.snap_x;
				held_y_q <= cur_q.snap_y;
				if (!replace_q) begin
					have_first_q <= 1'b1;
					if (kept_q != 2'd3) kept_q <= kept_q + 2'd1;
					if (have_first_q && cfg.prune) begin
						no_base_q <= 1'b0;
						base_x_q  <= dx_q;
						base_y_q  <= dy_q;
					end
				end
			end
			if (flush_fire) begin
				have_first_q <= 1'b0;
				no_base_q    <= 1'b1;
				kept_q       <= 2'd0;
				last_x_q     <= '0;
				last_y_q     <= '0;
				base_x_q     <= '0;
				base_y_q     <= '0;
				held_x_q     <= '0;
				held_y_q     <= '0;
			end
			if ((commit_fire && emit_held) || flush_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Vertex capture, decision and cross product datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_item;
			dx_q  <= gscp_pkg::DIR_W'(last_x_q) - gscp_pkg::DIR_W'(q_item.idx_x);
			dy_q  <= gscp_pkg::DIR_W'(last_y_q) - gscp_pkg::DIR_W'(q_item.idx_y);
		end
		if (eval_commit) begin
			keep_q    <= !(have_first_q && zero_delta);
			replace_q <= 1'b0;
		end
		if ((state_q == gscp_pkg::BS_EVAL) && need_mul) begin
			acc_q  <= '0;
			ma_q   <= gscp_pkg::PROD_W'(base_x_q);
			mb_q   <= gscp_pkg::PROD_W'(base_y_q);
			rx_q   <= dx_q;
			ry_q   <= dy_q;
			mcnt_q <= '0;
		end else if (state_q == gscp_pkg::BS_MUL) begin
			acc_q  <= acc_nxt;
			ma_q   <= ma_q <<< 1;
			mb_q   <= mb_q <<< 1;
			rx_q   <= rx_q >> 1;
			ry_q   <= ry_q >> 1;
			mcnt_q <= mcnt_q + gscp_pkg::MUL_CNT_W'(1);
			if (mul_last) begin
				keep_q    <= 1'b1;
				replace_q <= (acc_nxt == '0);
			end
		end
		// Output payload
		if (commit_fire && emit_held) begin
			out_x_q    <= held_x_q;
			out_y_q    <= held_y_q;
			out_last_q <= 1'b0;
			out_few_q  <= 1'b0;
		end else if (flush_fire) begin
			out_x_q    <= held_x_q;
			out_y_q    <= held_y_q;
			out_last_q <= 1'b1;
			out_few_q  <= (kept_q < 2'(gscp_pkg::KEPT_MIN));
		end
	end

	// Output channel
	always_comb begin
		out_ch.valid          = out_valid_q;
		out_ch.snapped_x      = out_x_q;
		out_ch.snapped_y      = out_y_q;
		out_ch.last_of_path   = out_last_q;
		out_ch.too_few_points = out_few_q;
	end

endmodule

`default_nettype wire

/* design/gscp_checker.sv */
// Port-level checks for the grid snap and collinear prune unit, attached to
// the top level by a bind. Depends on gscp_pkg.
`default_nettype none

module gscp_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_valid,
	input wire logic                                  in_ready,
	input wire logic                                  out_valid,
	input wire logic                                  out_ready,
	input wire logic signed [gscp_pkg::COORD_BITS-1:0] out_x,
	input wire logic signed [gscp_pkg::COORD_BITS-1:0] out_y,
	input wire logic                                  out_last,
	input wire logic                                  out_few,
	input wire logic                                  cfg_ready
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_last) && $stable(out_few))
		else $error("output payload changed while stalled");

	// The short-path flag only appears on the final vertex.
	a_few_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_few |-> out_last)
		else $error("too_few_points without last_of_path");

	// The divider is busy right after a vertex is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready while divider busy");

	// Configuration writes are never back-pressured.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind grid_snap_collinear_prune_unit gscp_checker u_gscp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_x     (out_ch.snapped_x),
	.out_y     (out_ch.snapped_y),
	.out_last  (out_ch.last_of_path),
	.out_few   (out_ch.too_few_points),
	.cfg_ready (cfg.ready)
);

`default_nettype wire
